### sv/arh_pkg.sv
// shared types, codes and default sizes for the address range histogram
package arh_pkg;

    // default sizes
    localparam int ENTRIES_DEF    = 256;
    localparam int ADDR_BITS_DEF  = 24;
    localparam int COUNT_BITS_DEF = 40;

    // fixed port widths of the word fields
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;
    localparam int RD_BITS     = 8;
    localparam int INDEX_BITS  = 8;
    localparam int USED_BITS   = 9;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SAMPLE   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ     = 2'd2;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUP    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FAIL   = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_IGNORE = 2'd3;

    // table update broadcast to every cell
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INCR   = 2'd1,
        OP_INSERT = 2'd2
    } cell_op_t;

    // control group from the sequencer to the cell row
    typedef struct packed {
        cell_op_t op;
        logic     load;
        logic     shift;
        logic     is_read;
    } cell_ctrl_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } seq_state_t;

endpackage

### sv/address_range_histogram_core.sv
// top level: command sequencer over a row of histogram table cells
// sequence: an accepted start passes the load, scan and finish states; done is registered from finish
// one command is in flight at a time; start is taken again in the done cycle
// the scan length is set by the collection chain, which moves the found entry one cell a cycle
// reset: table holds entry 0 (start 0, count 0), entries used 1, failure clear, enable 0
// done is a one-cycle strobe with no back-pressure from the receiver
module address_range_histogram_core #(
    parameter int ENTRIES    = arh_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS  = arh_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = arh_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [arh_pkg::CMD_BITS-1:0]       cmd,
    input  logic [ADDR_BITS-1:0]               address,
    input  logic [arh_pkg::RD_BITS-1:0]        entry_index,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    output logic                               done,
    output logic [arh_pkg::STATUS_BITS-1:0]    status,
    output logic [arh_pkg::INDEX_BITS-1:0]     bin_index,
    output logic [ADDR_BITS-1:0]               bin_start,
    output logic [COUNT_BITS-1:0]              bin_count,
    output logic [arh_pkg::USED_BITS-1:0]      entries_used
);
    import arh_pkg::*;

    localparam int IW  = $clog2(ENTRIES);
    localparam int UW  = $clog2(ENTRIES + 1);
    localparam int CLW = IW + ADDR_BITS + COUNT_BITS;
    localparam int RW  = (UW > RD_BITS) ? UW : RD_BITS;
    localparam logic [IW-1:0]         SCAN_LAST = IW'(ENTRIES - 2);
    localparam logic [UW-1:0]         FULL      = UW'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // sequencer and command registers
    seq_state_t             state_reg, state_next;
    logic [IW-1:0]          scan_cnt_reg, scan_cnt_next;
    logic [CMD_BITS-1:0]    cmd_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic [RD_BITS-1:0]     rd_reg;
    logic                   enable_reg;
    logic [UW-1:0]          used_reg, used_next;
    logic                   failed_reg, failed_next;
    logic                   done_reg;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [INDEX_BITS-1:0]  bin_index_reg, bin_index_next;
    logic [ADDR_BITS-1:0]   bin_start_reg, bin_start_next;
    logic [COUNT_BITS-1:0]  bin_count_reg, bin_count_next;
    logic [USED_BITS-1:0]   entries_used_reg, entries_used_next;

    // cell row wiring
    logic [ADDR_BITS-1:0]   start_w [ENTRIES];
    logic [COUNT_BITS-1:0]  count_w [ENTRIES];
    logic                   le_w    [ENTRIES];
    logic [CLW-1:0]         coll_w  [ENTRIES];
    cell_ctrl_t             ctrl;
    cell_op_t               op_sel;

    // tail of the collection chain
    logic [IW-1:0]          t_idx;
    logic [ADDR_BITS-1:0]   t_start;
    logic [COUNT_BITS-1:0]  t_count;
    logic                   accept;
    logic                   rd_ok;
    logic                   show;
    logic [IW-1:0]          res_idx;
    logic [ADDR_BITS-1:0]   res_start;
    logic [COUNT_BITS-1:0]  res_count;
    logic [STATUS_BITS-1:0] res_status;
    logic [UW-1:0]          res_used;
    logic                   res_failed;

    assign accept = start && !busy;
    assign {t_idx, t_start, t_count} = coll_w[ENTRIES-1];
    assign rd_ok = RW'(rd_reg) < RW'(used_reg);

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            logic [ADDR_BITS-1:0]  l_start;
            logic [COUNT_BITS-1:0] l_count;
            logic                  l_le;
            logic [CLW-1:0]        l_coll;
            logic                  r_le;

            if (gi == 0)
            begin : g_head
                assign l_start = '0;
                assign l_count = '0;
                assign l_le    = 1'b1;
                assign l_coll  = '0;
            end
            else
            begin : g_link
                assign l_start = start_w[gi-1];
                assign l_count = count_w[gi-1];
                assign l_le    = le_w[gi-1];
                assign l_coll  = coll_w[gi-1];
            end

            if (gi == ENTRIES - 1)
            begin : g_tail
                assign r_le = 1'b0;
            end
            else
            begin : g_right
                assign r_le = le_w[gi+1];
            end

            arh_cell #(
                .IDX        (gi),
                .ENTRIES    (ENTRIES),
                .ADDR_BITS  (ADDR_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .addr       (addr_reg),
                .rd         (rd_reg),
                .used       (used_reg),
                .left_start (l_start),
                .left_count (l_count),
                .left_le    (l_le),
                .left_coll  (l_coll),
                .right_le   (r_le),
                .start_q    (start_w[gi]),
                .count_q    (count_w[gi]),
                .le         (le_w[gi]),
                .coll_q     (coll_w[gi])
            );
        end
    endgenerate

    // command decision on the collected entry
    always_comb
    begin
        res_status = ST_IGNORE;
        show       = 1'b0;
        res_idx    = t_idx;
        res_start  = t_start;
        res_count  = t_count;
        res_used   = used_reg;
        res_failed = failed_reg;
        op_sel     = OP_NONE;
        if (failed_reg)
        begin
            res_status = ST_FAIL;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_REGISTER:
                begin
                    if (t_start == addr_reg)
                    begin
                        res_status = ST_DUP;
                        show       = 1'b1;
                    end
                    else if (used_reg == FULL)
                    begin
                        res_status = ST_FAIL;
                        res_failed = 1'b1;
                    end
                    else
                    begin
                        res_status = ST_OK;
                        show       = 1'b1;
                        op_sel     = OP_INSERT;
                        res_idx    = t_idx + 1'b1;
                        res_start  = addr_reg;
                        res_count  = '0;
                        res_used   = used_reg + 1'b1;
                    end
                end
                CMD_SAMPLE:
                begin
                    if (enable_reg)
                    begin
                        res_status = ST_OK;
                        show       = 1'b1;
                        op_sel     = OP_INCR;
                        if (t_count != COUNT_MAX)
                        begin
                            res_count = t_count + 1'b1;
                        end
                    end
                end
                CMD_READ:
                begin
                    if (rd_ok)
                    begin
                        res_status = ST_OK;
                        show       = 1'b1;
                    end
                end
                default:
                begin
                    res_status = ST_IGNORE;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        scan_cnt_next     = scan_cnt_reg;
        used_next         = used_reg;
        failed_next       = failed_reg;
        status_next       = status_reg;
        bin_index_next    = bin_index_reg;
        bin_start_next    = bin_start_reg;
        bin_count_next    = bin_count_reg;
        entries_used_next = entries_used_reg;
        ctrl.op           = OP_NONE;
        ctrl.load         = 1'b0;
        ctrl.shift        = 1'b0;
        ctrl.is_read      = (cmd_reg == CMD_READ);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                ctrl.load     = 1'b1;
                scan_cnt_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                ctrl.shift    = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCAN_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                ctrl.op           = op_sel;
                used_next         = res_used;
                failed_next       = res_failed;
                status_next       = res_status;
                bin_index_next    = show ? INDEX_BITS'(res_idx) : '0;
                bin_start_next    = show ? res_start : '0;
                bin_count_next    = show ? res_count : '0;
                entries_used_next = USED_BITS'(res_used);
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            enable_reg   <= 1'b0;
            used_reg     <= UW'(1);
            failed_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            used_reg     <= used_next;
            failed_reg   <= failed_next;
            done_reg     <= (state_reg == S_FINISH);
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    // command capture and result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            addr_reg <= address;
            rd_reg   <= entry_index;
        end
        status_reg       <= status_next;
        bin_index_reg    <= bin_index_next;
        bin_start_reg    <= bin_start_next;
        bin_count_reg    <= bin_count_next;
        entries_used_reg <= entries_used_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign bin_index    = bin_index_reg;
    assign bin_start    = bin_start_reg;
    assign bin_count    = bin_count_reg;
    assign entries_used = entries_used_reg;

endmodule

### sv/arh_cell.sv
// one table cell: region start, counter and a stage of the result collection chain
module arh_cell #(
    parameter int IDX        = 0,
    parameter int ENTRIES    = arh_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS  = arh_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = arh_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  arh_pkg::cell_ctrl_t                  ctrl,
    input  logic [ADDR_BITS-1:0]                 addr,
    input  logic [arh_pkg::RD_BITS-1:0]          rd,
    input  logic [$clog2(ENTRIES+1)-1:0]         used,
    input  logic [ADDR_BITS-1:0]                 left_start,
    input  logic [COUNT_BITS-1:0]                left_count,
    input  logic                                 left_le,
    input  logic [$clog2(ENTRIES)+ADDR_BITS+COUNT_BITS-1:0] left_coll,
    input  logic                                 right_le,
    output logic [ADDR_BITS-1:0]                 start_q,
    output logic [COUNT_BITS-1:0]                count_q,
    output logic                                 le,
    output logic [$clog2(ENTRIES)+ADDR_BITS+COUNT_BITS-1:0] coll_q
);
    import arh_pkg::*;

    localparam int IW  = $clog2(ENTRIES);
    localparam int UW  = $clog2(ENTRIES + 1);
    localparam int CLW = IW + ADDR_BITS + COUNT_BITS;
    localparam logic [UW-1:0]         POS       = UW'(IDX);
    localparam logic [IW-1:0]         MY_INDEX  = IW'(IDX);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam bit                    RD_REACH  = (IDX < (1 << RD_BITS));

    logic [ADDR_BITS-1:0]  start_reg, start_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [CLW-1:0]        coll_reg, coll_next;
    logic                  valid;
    logic                  hit;
    logic                  new_here;
    logic                  shift_here;
    logic                  rd_hit;
    logic                  sel;

    // position in the sorted table relative to the broadcast address
    assign valid      = POS < used;
    assign le         = valid && (start_reg <= addr);
    assign hit        = le && !right_le;
    assign new_here   = left_le && !le;
    assign shift_here = !left_le && !le;
    assign rd_hit     = RD_REACH && (rd == RD_BITS'(IDX));
    assign sel        = ctrl.is_read ? rd_hit : hit;

    // table update
    always_comb
    begin
        start_next = start_reg;
        count_next = count_reg;
        unique case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_INCR:
            begin
                if (hit && (count_reg != COUNT_MAX))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (new_here)
                begin
                    start_next = addr;
                    count_next = '0;
                end
                else if (shift_here)
                begin
                    start_next = left_start;
                    count_next = left_count;
                end
            end
            default:
            begin
            end
        endcase
    end

    // collection chain: selected cell loads its entry, then the entries are ORed toward the tail
    always_comb
    begin
        coll_next = coll_reg;
        if (ctrl.load)
        begin
            coll_next = sel ? {MY_INDEX, start_reg, count_reg} : '0;
        end
        else if (ctrl.shift)
        begin
            coll_next = coll_reg | left_coll;
        end
    end

    // entry 0 is fixed at start 0 with a cleared counter after reset
    generate
        if (IDX == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    start_reg <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    start_reg <= start_next;
                    count_reg <= count_next;
                end
            end
        end
        else
        begin : g_other
            always_ff @(posedge clk)
            begin
                start_reg <= start_next;
                count_reg <= count_next;
            end
        end
    endgenerate

    // collection register
    always_ff @(posedge clk)
    begin
        coll_reg <= coll_next;
    end

    assign start_q = start_reg;
    assign count_q = count_reg;
    assign coll_q  = coll_reg;

endmodule

### sv/arh_checker.sv
// port-level checks for the address range histogram core and their bind
module arh_checker #(
    parameter int ADDR_BITS  = arh_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = arh_pkg::COUNT_BITS_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [arh_pkg::STATUS_BITS-1:0] status,
    input logic [arh_pkg::INDEX_BITS-1:0]  bin_index,
    input logic [ADDR_BITS-1:0]            bin_start,
    input logic [COUNT_BITS-1:0]           bin_count
);
    import arh_pkg::*;

    // a result word is only shown once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    // an accepted command occupies the core in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not make the core busy");

    // one word per command, never two strobes back to back
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // refused or failed commands carry no entry
    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FAIL || status == ST_IGNORE)) |->
            (bin_index == '0 && bin_start == '0 && bin_count == '0))
        else $error("refused command returned entry data");

endmodule

bind address_range_histogram_core arh_checker #(
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_arh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .bin_index (bin_index),
    .bin_start (bin_start),
    .bin_count (bin_count)
);

### verif/testbench.sv
// self-checking testbench for the address range histogram core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import arh_pkg::*;

    localparam int TBL_DEPTH = ENTRIES_DEF;
    localparam int ADDR_W    = ADDR_BITS_DEF;
    localparam int CNT_W     = COUNT_BITS_DEF;

    // code with no command behind it
    localparam logic [CMD_BITS-1:0] CMD_UNKNOWN = 2'd3;

    // cycles with neither a word taken nor a result seen before giving up
    localparam int STALL_LIMIT      = 4000;
    localparam int RANDOM_PER_PHASE = 110;
    localparam int DIRECTED_ROWS    = 25;

    // one result word
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [INDEX_BITS-1:0]  bin_index;
        logic [ADDR_W-1:0]      bin_start;
        logic [CNT_W-1:0]       bin_count;
        logic [USED_BITS-1:0]   entries_used;
    } bin_result_t;

    // one directed row: enable setting, command word, optional literal result
    typedef struct {
        bit                  en;
        logic [CMD_BITS-1:0] op;
        logic [ADDR_W-1:0]   addr;
        logic [RD_BITS-1:0]  rd;
        bit                  literal_check;
        bin_result_t         want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [CMD_BITS-1:0]    cmd;
    logic [ADDR_W-1:0]      address;
    logic [RD_BITS-1:0]     entry_index;
    logic                   cfg_we;
    logic                   cfg_wdata;
    logic                   done;
    logic [STATUS_BITS-1:0] status;
    logic [INDEX_BITS-1:0]  bin_index;
    logic [ADDR_W-1:0]      bin_start;
    logic [CNT_W-1:0]       bin_count;
    logic [USED_BITS-1:0]   entries_used;

    // shadow copy of the region table and its settings
    logic [ADDR_W-1:0] region_starts [TBL_DEPTH];
    logic [CNT_W-1:0]  region_counts [TBL_DEPTH];
    int unsigned       regions_used;
    bit                table_failed;
    bit                count_enable;

    bin_result_t expected_bins [$];
    stim_row_t   directed_rows [DIRECTED_ROWS];
    int          idle_pct;
    int          mismatches;
    int          stall_cycles = 0;
    int          phase_idle [4] = '{0, 71, 0, 29};
    bit          phase_en [4]   = '{1'b1, 1'b0, 1'b1, 1'b1};

    always #1 clk = ~clk;

    address_range_histogram_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .address      (address),
        .entry_index  (entry_index),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .status       (status),
        .bin_index    (bin_index),
        .bin_start    (bin_start),
        .bin_count    (bin_count),
        .entries_used (entries_used)
    );

    // last valid region whose start is not above the address
    function automatic int locate_bin(logic [ADDR_W-1:0] a);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = regions_used;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (region_starts[mid] <= a)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic bit is_registered(logic [ADDR_W-1:0] a);
        return region_starts[locate_bin(a)] == a;
    endfunction

    function automatic logic [ADDR_W-1:0] known_start();
        return region_starts[$urandom_range(regions_used - 1)];
    endfunction

    // apply one word to the shadow table and build the result it must give
    function automatic bin_result_t histogram_step(logic [CMD_BITS-1:0] op,
                                                   logic [ADDR_W-1:0] a,
                                                   logic [RD_BITS-1:0] rd);
        bin_result_t r;
        int          hit;
        int          i;
        bit          show;
        r    = '0;
        hit  = 0;
        show = 1'b0;
        if (table_failed)
            r.status = ST_FAIL;
        else
        begin
            case (op)
                CMD_REGISTER:
                begin
                    hit = locate_bin(a);
                    if (region_starts[hit] == a)
                    begin
                        r.status = ST_DUP;
                        show     = 1'b1;
                    end
                    else if (regions_used >= TBL_DEPTH)
                    begin
                        table_failed = 1'b1;
                        r.status     = ST_FAIL;
                    end
                    else
                    begin
                        // open a slot after the found region
                        for (i = int'(regions_used) - 1; i > hit; i--)
                        begin
                            region_starts[i + 1] = region_starts[i];
                            region_counts[i + 1] = region_counts[i];
                        end
                        hit                = hit + 1;
                        region_starts[hit] = a;
                        region_counts[hit] = '0;
                        regions_used++;
                        r.status = ST_OK;
                        show     = 1'b1;
                    end
                end
                CMD_SAMPLE:
                begin
                    if (!count_enable)
                        r.status = ST_IGNORE;
                    else
                    begin
                        hit = locate_bin(a);
                        // counter saturates at all ones
                        if (region_counts[hit] != '1)
                            region_counts[hit] = region_counts[hit] + 1'b1;
                        r.status = ST_OK;
                        show     = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (rd < regions_used)
                    begin
                        hit      = int'(rd);
                        r.status = ST_OK;
                        show     = 1'b1;
                    end
                    else
                        r.status = ST_IGNORE;
                end
                default:
                    r.status = ST_IGNORE;
            endcase
        end
        if (show)
        begin
            r.bin_index = hit[INDEX_BITS-1:0];
            r.bin_start = region_starts[hit];
            r.bin_count = region_counts[hit];
        end
        r.entries_used = regions_used[USED_BITS-1:0];
        return r;
    endfunction

    // present one word at the falling edge and hold it until taken
    task automatic send_word(logic [CMD_BITS-1:0] op, logic [ADDR_W-1:0] a,
                             logic [RD_BITS-1:0] rd, bit literal_check,
                             bin_result_t want);
        bin_result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        cmd         = op;
        address     = a;
        entry_index = rd;
        start       = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predicted = histogram_step(op, a, rd);
        expected_bins.push_back(literal_check ? want : predicted);
        @(negedge clk);
    endtask

    task automatic send_predicted(logic [CMD_BITS-1:0] op, logic [ADDR_W-1:0] a,
                                  logic [RD_BITS-1:0] rd);
        send_word(op, a, rd, 1'b0, '0);
    endtask

    // enable is written only with the block idle and nothing outstanding
    task automatic set_enable(bit v);
        start = 1'b0;
        while (expected_bins.size() != 0 || busy)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we       = 1'b0;
        count_enable = v;
    endtask

    // mostly well-formed traffic aimed at existing regions and their borders
    task automatic random_word(int ins_pct, int unsigned cap);
        logic [CMD_BITS-1:0] op;
        logic [ADDR_W-1:0]   a;
        logic [RD_BITS-1:0]  rd;
        int unsigned         roll;
        int unsigned         pick;
        roll = $urandom_range(99);
        pick = $urandom_range(9);
        a    = ADDR_W'($urandom);
        rd   = RD_BITS'($urandom);
        if (roll < ins_pct)
        begin
            op = CMD_REGISTER;
            if (pick == 6 || pick == 7)
                a = known_start();
            else if (pick == 8)
                a = known_start() + 1'b1;
            else if (pick == 9)
                a = known_start() - 1'b1;
            // keep the table below its cap until the fill phase
            if (regions_used >= cap && !is_registered(a))
                a = known_start();
        end
        else if (roll < ins_pct + (100 - ins_pct) * 2 / 3)
        begin
            op = CMD_SAMPLE;
            if (pick >= 4 && pick <= 6)
                a = known_start();
            else if (pick == 7)
                a = known_start() - 1'b1;
            else if (pick == 8)
                a = known_start() + 1'b1;
            else if (pick == 9)
                a = $urandom_range(1) ? '1 : '0;
        end
        else if (roll < 97)
        begin
            op = CMD_READ;
            if (pick < 8)
                rd = RD_BITS'($urandom_range(regions_used - 1));
        end
        else
            op = CMD_UNKNOWN;
        send_predicted(op, a, rd);
    endtask

    // compare one field of a result word
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        bin_result_t want;
        if (rst_n && done)
        begin
            if (expected_bins.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word with none expected, status %0d index %0d",
                         $time, status, bin_index);
            end
            else
            begin
                want = expected_bins.pop_front();
                check_field("status", 64'(want.status), 64'(status));
                check_field("bin_index", 64'(want.bin_index), 64'(bin_index));
                check_field("bin_start", 64'(want.bin_start), 64'(bin_start));
                check_field("bin_count", 64'(want.bin_count), 64'(bin_count));
                check_field("entries_used", 64'(want.entries_used), 64'(entries_used));
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // stimulus
    initial
    begin
        logic [ADDR_W-1:0] fresh;
        int                ph;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_REGISTER;
        address      = '0;
        entry_index  = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        idle_pct     = 0;
        mismatches   = 0;
        region_starts[0] = '0;
        region_counts[0] = '0;
        regions_used = 1;
        table_failed = 1'b0;
        count_enable = 1'b0;

        // extremes, every command and the ignore and duplicate answers
        directed_rows = '{
            '{1'b0, CMD_READ, 24'h000000, 8'h00, 1'b1, '{ST_OK, 8'd0, 24'h0, 40'd0, 9'd1}},
            '{1'b0, CMD_READ, 24'h000000, 8'h01, 1'b1, '{ST_IGNORE, 8'd0, 24'h0, 40'd0, 9'd1}},
            '{1'b0, CMD_READ, 24'hFFFFFF, 8'hFF, 1'b1, '{ST_IGNORE, 8'd0, 24'h0, 40'd0, 9'd1}},
            '{1'b0, CMD_SAMPLE, 24'hFFFFFF, 8'h00, 1'b1,
              '{ST_IGNORE, 8'd0, 24'h0, 40'd0, 9'd1}},
            '{1'b0, CMD_REGISTER, 24'h000000, 8'h00, 1'b1,
              '{ST_DUP, 8'd0, 24'h0, 40'd0, 9'd1}},
            '{1'b0, CMD_UNKNOWN, 24'hFFFFFF, 8'hFF, 1'b1,
              '{ST_IGNORE, 8'd0, 24'h0, 40'd0, 9'd1}},
            '{1'b0, CMD_REGISTER, 24'hFFFFFF, 8'h00, 1'b1,
              '{ST_OK, 8'd1, 24'hFFFFFF, 40'd0, 9'd2}},
            '{1'b0, CMD_REGISTER, 24'h800000, 8'h00, 1'b1,
              '{ST_OK, 8'd1, 24'h800000, 40'd0, 9'd3}},
            '{1'b0, CMD_REGISTER, 24'h000001, 8'h00, 1'b1,
              '{ST_OK, 8'd1, 24'h000001, 40'd0, 9'd4}},
            '{1'b0, CMD_REGISTER, 24'h800000, 8'h00, 1'b1,
              '{ST_DUP, 8'd2, 24'h800000, 40'd0, 9'd4}},
            '{1'b0, CMD_READ, 24'h000000, 8'h03, 1'b1,
              '{ST_OK, 8'd3, 24'hFFFFFF, 40'd0, 9'd4}},
            '{1'b1, CMD_SAMPLE, 24'h000000, 8'h00, 1'b1,
              '{ST_OK, 8'd0, 24'h000000, 40'd1, 9'd4}},
            '{1'b1, CMD_SAMPLE, 24'h000001, 8'h00, 1'b1,
              '{ST_OK, 8'd1, 24'h000001, 40'd1, 9'd4}},
            '{1'b1, CMD_SAMPLE, 24'h7FFFFF, 8'h00, 1'b0, '0},
            '{1'b1, CMD_SAMPLE, 24'h800000, 8'h00, 1'b0, '0},
            '{1'b1, CMD_SAMPLE, 24'hFFFFFE, 8'h00, 1'b0, '0},
            '{1'b1, CMD_SAMPLE, 24'hFFFFFF, 8'h00, 1'b0, '0},
            '{1'b1, CMD_SAMPLE, 24'hAAAAAA, 8'h00, 1'b0, '0},
            '{1'b1, CMD_REGISTER, 24'h555555, 8'h00, 1'b0, '0},
            '{1'b1, CMD_SAMPLE, 24'h555555, 8'h00, 1'b0, '0},
            '{1'b1, CMD_READ, 24'h000000, 8'hAA, 1'b1, '{ST_IGNORE, 8'd0, 24'h0, 40'd0, 9'd5}},
            '{1'b1, CMD_READ, 24'h000000, 8'h55, 1'b1, '{ST_IGNORE, 8'd0, 24'h0, 40'd0, 9'd5}},
            '{1'b1, CMD_UNKNOWN, 24'h000000, 8'h00, 1'b1,
              '{ST_IGNORE, 8'd0, 24'h0, 40'd0, 9'd5}},
            '{1'b1, CMD_READ, 24'h000000, 8'h04, 1'b0, '0},
            '{1'b0, CMD_SAMPLE, 24'h555555, 8'h00, 1'b1,
              '{ST_IGNORE, 8'd0, 24'h0, 40'd0, 9'd5}}
        };

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        set_enable(1'b0);

        // directed table
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].en != count_enable)
                set_enable(directed_rows[k].en);
            send_word(directed_rows[k].op, directed_rows[k].addr, directed_rows[k].rd,
                      directed_rows[k].literal_check, directed_rows[k].want);
        end

        // random phases with the table kept short of full
        for (ph = 0; ph < 4; ph++)
        begin
            set_enable(phase_en[ph]);
            idle_pct = phase_idle[ph];
            repeat (RANDOM_PER_PHASE) random_word(25, 200);
        end

        // fill the table to its last entry
        set_enable(1'b1);
        idle_pct = 29;
        while (regions_used < TBL_DEPTH)
            random_word(60, TBL_DEPTH);

        // duplicate on a full table, then the insert that trips the sticky failure
        idle_pct = 0;
        send_predicted(CMD_REGISTER, known_start(), 8'h00);
        do
            fresh = ADDR_W'($urandom);
        while (is_registered(fresh));
        send_predicted(CMD_REGISTER, fresh, 8'h00);

        // every command is refused from here on
        send_predicted(CMD_SAMPLE, known_start(), 8'h00);
        send_predicted(CMD_READ, '0, 8'h00);
        send_predicted(CMD_REGISTER, ADDR_W'($urandom), 8'h00);
        send_predicted(CMD_UNKNOWN, '1, 8'hFF);
        set_enable(1'b0);
        send_predicted(CMD_SAMPLE, '1, 8'h00);
        send_predicted(CMD_READ, '0, 8'hFF);

        // drain and watch for stray results
        start = 1'b0;
        while (expected_bins.size() != 0)
            @(negedge clk);
        repeat (TBL_DEPTH + 40) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
